// ===== sv/r2fft_pkg.sv =====
// Shared types and constants for the radix-2 frame FFT.
package r2fft_pkg;

	localparam int WORK_BITS = 28;
	localparam int CMD_WRITE = 0;
	localparam int CMD_READ = 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BR_RD,
		ST_BR_LA,
		ST_BR_LB,
		ST_BR_WA,
		ST_BR_WB,
		ST_BF_RA,
		ST_BF_LB,
		ST_BF_LA,
		ST_BF_MUL,
		ST_BF_WA,
		ST_BF_WB,
		ST_RD_WAIT,
		ST_RD_OUT
	} state_t;

	// Datapath commands from the controller
	typedef struct packed {
		logic load_sample;
		logic br_swap_a;
		logic br_swap_b;
		logic latch_a;
		logic latch_b;
		logic mul;
		logic wr_a;
		logic wr_b;
		logic rd_present;
		logic ready_set;
		logic ready_clr;
	} ctrl_t;

	// Saturate a wide sum to the working width
	function automatic logic signed [WORK_BITS-1:0] sat_work(input logic signed [WORK_BITS+1:0] v);
		logic signed [WORK_BITS+1:0] hi;
		logic signed [WORK_BITS+1:0] lo;
		begin
			hi = (WORK_BITS+2)'((64'sd1 <<< (WORK_BITS - 1)) - 1);
			lo = -hi - 1;
			if (v > hi) sat_work = hi[WORK_BITS-1:0];
			else if (v < lo) sat_work = lo[WORK_BITS-1:0];
			else sat_work = v[WORK_BITS-1:0];
		end
	endfunction

endpackage

// ===== sv/r2fft_ram.sv =====
// Generic single-port RAM with registered read.
module r2fft_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/r2fft_twiddle.sv =====
// Twiddle ROM: cos and -sin in TWIDDLE_BITS-1 fraction bits, built at elaboration.
module r2fft_twiddle #(
	parameter int POINTS = 4096,
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                              clk,
	input  logic [$clog2(POINTS)-2:0]         idx,
	output logic signed [TWIDDLE_BITS-1:0]    tw_re,
	output logic signed [TWIDDLE_BITS-1:0]    tw_im
);

	localparam int HALF = POINTS / 2;
	localparam int LIM = (1 << (TWIDDLE_BITS - 1)) - 1;
	localparam real PI = 3.14159265358979323846264338327950288;
	// Angle step between table entries
	localparam real STEP = 2.0 * PI / real'(POINTS);

	// Round half away from zero
	function automatic int rnd(input real v);
		real a;
		begin
			a = (v < 0.0) ? -v : v;
			rnd = int'($floor(a * real'(1 << (TWIDDLE_BITS - 1)) + 0.5));
			if (v < 0.0) rnd = -rnd;
		end
	endfunction

	function automatic logic [2*TWIDDLE_BITS-1:0] entry(input int k);
		int c;
		int s;
		real x;
		begin
			if (k <= POINTS / 4) begin
				x = STEP * real'(k);
				c = rnd($cos(x));
				s = rnd($sin(x));
			end else begin
				x = STEP * real'(HALF - k);
				c = -rnd($cos(x));
				s = rnd($sin(x));
			end
			if (c > LIM) c = LIM;
			entry = {TWIDDLE_BITS'(c), TWIDDLE_BITS'(-s)};
		end
	endfunction

	logic [2*TWIDDLE_BITS-1:0] rom [HALF];
	logic [2*TWIDDLE_BITS-1:0] rd_q;

	for (genvar g = 0; g < HALF; g++) begin : g_rom
		assign rom[g] = entry(g);
	end

	always_ff @(posedge clk) rd_q <= rom[idx];

	assign tw_re = rd_q[2*TWIDDLE_BITS-1:TWIDDLE_BITS];
	assign tw_im = rd_q[TWIDDLE_BITS-1:0];

endmodule

// ===== sv/r2fft_datapath.sv =====
// Datapath: working store, twiddle ROM, butterfly arithmetic and result register.
module r2fft_datapath #(
	parameter int POINTS = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  r2fft_pkg::ctrl_t                      ctl,
	input  logic [$clog2(POINTS)-1:0]             addr,
	input  logic [$clog2(POINTS)-2:0]             tw_idx,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic signed [r2fft_pkg::WORK_BITS-1:0] bin_real,
	output logic signed [r2fft_pkg::WORK_BITS-1:0] bin_imag,
	output logic                                  ready_res
);

	localparam int W = r2fft_pkg::WORK_BITS;
	localparam int PW = W + TWIDDLE_BITS + 1;
	localparam int SH = TWIDDLE_BITS - 1;

	logic         we;
	logic [W-1:0] wd_re, wd_im, rd_re, rd_im;
	logic signed [W-1:0] a_re_q, a_im_q, b_re_q, b_im_q, za_re_q, za_im_q;
	logic signed [W-1:0] zb_re_q, zb_im_q;
	logic signed [TWIDDLE_BITS-1:0] w_re, w_im;
	logic signed [PW-1:0] pr, pi;
	logic signed [W+1:0] zr, zi;
	logic ready_q;

	r2fft_ram #(.WIDTH(W), .DEPTH(POINTS)) u_re (
		.clk(clk), .we(we), .addr(addr), .wdata(wd_re), .rdata(rd_re));
	r2fft_ram #(.WIDTH(W), .DEPTH(POINTS)) u_im (
		.clk(clk), .we(we), .addr(addr), .wdata(wd_im), .rdata(rd_im));
	r2fft_twiddle #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
		.clk(clk), .idx(tw_idx), .tw_re(w_re), .tw_im(w_im));

	// Store write selection
	always_comb begin
		we = ctl.load_sample | ctl.br_swap_a | ctl.br_swap_b | ctl.wr_a | ctl.wr_b;
		wd_re = '0;
		wd_im = '0;
		if (ctl.load_sample) begin
			wd_re = W'(sample);
		end else if (ctl.br_swap_a) begin
			wd_re = b_re_q; wd_im = b_im_q;
		end else if (ctl.br_swap_b) begin
			wd_re = a_re_q; wd_im = a_im_q;
		end else if (ctl.wr_a) begin
			wd_re = za_re_q; wd_im = za_im_q;
		end else if (ctl.wr_b) begin
			wd_re = zb_re_q; wd_im = zb_im_q;
		end
	end

	// Complex product with round-to-nearest; combinational 28x16 multipliers
	assign pr = PW'(w_re * b_re_q) - PW'(w_im * b_im_q) + PW'(1 << (SH - 1));
	assign pi = PW'(w_re * b_im_q) + PW'(w_im * b_re_q) + PW'(1 << (SH - 1));
	assign zr = (W+2)'(pr >>> SH);
	assign zi = (W+2)'(pi >>> SH);

	always_ff @(posedge clk) begin
		if (ctl.latch_a) begin
			a_re_q <= rd_re; a_im_q <= rd_im;
		end
		if (ctl.latch_b) begin
			b_re_q <= rd_re; b_im_q <= rd_im;
		end
		if (ctl.mul) begin
			za_re_q <= r2fft_pkg::sat_work((W+2)'(a_re_q) + zr);
			za_im_q <= r2fft_pkg::sat_work((W+2)'(a_im_q) + zi);
			zb_re_q <= r2fft_pkg::sat_work((W+2)'(a_re_q) - zr);
			zb_im_q <= r2fft_pkg::sat_work((W+2)'(a_im_q) - zi);
		end
		if (ctl.rd_present) begin
			bin_real <= ready_q ? rd_re : '0;
			bin_imag <= ready_q ? rd_im : '0;
		end
	end

	// Result-held flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			ready_res <= 1'b0;
		end else begin
			if (ctl.ready_set) ready_q <= 1'b1;
			else if (ctl.ready_clr) ready_q <= 1'b0;
			if (ctl.rd_present) ready_res <= ready_q;
		end
	end

endmodule

// ===== sv/r2fft_ctrl.sv =====
// Controller: sample loading, bit reversal pass, butterfly sequencing and bin reads.
module r2fft_ctrl #(
	parameter int POINTS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          command,
	input  logic [11:0]                   bin_index,
	output logic                          busy,
	output logic                          done,
	output r2fft_pkg::ctrl_t              ctl,
	output logic [$clog2(POINTS)-1:0]     addr,
	output logic [$clog2(POINTS)-2:0]     tw_idx
);

	localparam int AW = $clog2(POINTS);
	localparam int SW = $clog2(AW + 1);

	r2fft_pkg::state_t state_q, state_d;
	logic [AW-1:0] cnt_q, cnt_d;      // sample count / bit-reverse index
	logic [AW-2:0] bf_q, bf_d;        // butterfly number within stage
	logic [SW-1:0] stg_q, stg_d;      // stage, 0 .. AW-1
	logic [AW-1:0] rd_q, rd_d;
	logic [AW-1:0] rev, pa, pb;
	logic [AW-2:0] m_lo, twx;
	logic [AW-1:0] hmask;

	always_comb begin
		for (int b = 0; b < AW; b++) rev[b] = cnt_q[AW-1-b];
		// half = 2^stg; a = insert a zero at bit stg of bf
		hmask = AW'((1 << stg_q) - 1);
		pa = ((AW'(bf_q) & ~hmask) << 1) | (AW'(bf_q) & hmask);
		pb = pa | AW'(1 << stg_q);
		m_lo = bf_q & hmask[AW-2:0];
		twx = (AW-1)'(m_lo << (AW - 1 - stg_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r2fft_pkg::ST_IDLE;
			cnt_q <= '0;
			bf_q <= '0;
			stg_q <= '0;
			rd_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			bf_q <= bf_d;
			stg_q <= stg_d;
			rd_q <= rd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		bf_d = bf_q;
		stg_d = stg_q;
		rd_d = rd_q;
		ctl = '0;
		addr = cnt_q;
		tw_idx = twx;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			r2fft_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (command == 1'(r2fft_pkg::CMD_WRITE)) begin
						ctl.load_sample = 1'b1;
						ctl.ready_clr = (cnt_q == '0);
						cnt_d = cnt_q + 1'b1;
						if (cnt_q == AW'(POINTS - 1)) state_d = r2fft_pkg::ST_BR_RD;
					end else begin
						rd_d = AW'(bin_index);
						addr = AW'(bin_index);
						state_d = r2fft_pkg::ST_RD_WAIT;
					end
				end
			end
			// bit reversal: read i, then j, swap when i < j
			r2fft_pkg::ST_BR_RD: begin
				if (cnt_q < rev) begin
					addr = cnt_q;
					state_d = r2fft_pkg::ST_BR_LA;
				end else begin
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == AW'(POINTS - 1)) begin
						bf_d = '0;
						stg_d = '0;
						state_d = r2fft_pkg::ST_BF_RA;
					end
				end
			end
			r2fft_pkg::ST_BR_LA: begin
				ctl.latch_a = 1'b1;
				addr = rev;
				state_d = r2fft_pkg::ST_BR_LB;
			end
			r2fft_pkg::ST_BR_LB: begin
				ctl.latch_b = 1'b1;
				state_d = r2fft_pkg::ST_BR_WA;
			end
			r2fft_pkg::ST_BR_WA: begin
				addr = cnt_q;
				ctl.br_swap_a = 1'b1;
				state_d = r2fft_pkg::ST_BR_WB;
			end
			r2fft_pkg::ST_BR_WB: begin
				addr = rev;
				ctl.br_swap_b = 1'b1;
				cnt_d = cnt_q + 1'b1;
				state_d = r2fft_pkg::ST_BR_RD;
			end
			// butterfly: read b then a, multiply, write a then b
			r2fft_pkg::ST_BF_RA: begin
				addr = pb;
				state_d = r2fft_pkg::ST_BF_LB;
			end
			r2fft_pkg::ST_BF_LB: begin
				ctl.latch_b = 1'b1;
				addr = pa;
				state_d = r2fft_pkg::ST_BF_LA;
			end
			r2fft_pkg::ST_BF_LA: begin
				ctl.latch_a = 1'b1;
				state_d = r2fft_pkg::ST_BF_MUL;
			end
			r2fft_pkg::ST_BF_MUL: begin
				ctl.mul = 1'b1;
				state_d = r2fft_pkg::ST_BF_WA;
			end
			r2fft_pkg::ST_BF_WA: begin
				addr = pa;
				ctl.wr_a = 1'b1;
				state_d = r2fft_pkg::ST_BF_WB;
			end
			r2fft_pkg::ST_BF_WB: begin
				addr = pb;
				ctl.wr_b = 1'b1;
				bf_d = bf_q + 1'b1;
				state_d = r2fft_pkg::ST_BF_RA;
				if (bf_q == (AW-1)'(POINTS / 2 - 1)) begin
					stg_d = stg_q + 1'b1;
					if (stg_q == SW'(AW - 1)) begin
						ctl.ready_set = 1'b1;
						cnt_d = '0;
						state_d = r2fft_pkg::ST_IDLE;
					end
				end
			end
			r2fft_pkg::ST_RD_WAIT: begin
				addr = rd_q;
				ctl.rd_present = 1'b1;
				state_d = r2fft_pkg::ST_RD_OUT;
			end
			// Result word on the ports for this cycle
			r2fft_pkg::ST_RD_OUT: begin
				done = 1'b1;
				state_d = r2fft_pkg::ST_IDLE;
			end
			default: state_d = r2fft_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== sv/radix2_fft_frame_top.sv =====
// Top level of the radix-2 frame FFT: controller plus datapath.
//
// Usage: pulse start with busy low. command 0 writes the next real sample
// of the frame (imaginary part zero); command 1 reads one bin, bin_index
// taken modulo POINTS.
// A write is taken with busy staying low, so samples may come every cycle.
// The POINTS-th write launches the transform: a bit-reversal pass that
// reads and swaps each index pair with i < j, then log2(POINTS) stages of
// POINTS/2 butterflies through the single store port; busy stays high.
// A read keeps busy high through states RD_WAIT and RD_OUT; bin_real,
// bin_imag and ready_res are valid for one cycle while done is high, in
// RD_OUT, so a new read is taken only after the previous word is out. With
// no finished transform the word is zero with ready_res low. The first
// sample of a new frame clears the flag. Reset (arst_n low) empties the
// frame count and clears the ready flag; store contents are undefined
// until written. The receiver cannot stall: each result word is on the
// ports in the strobe cycle and held until the next read replaces it.
module radix2_fft_frame_top #(
	parameter int POINTS = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	output logic                                   done,
	input  logic                                   command,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic [11:0]                            bin_index,
	output logic signed [r2fft_pkg::WORK_BITS-1:0] bin_real,
	output logic signed [r2fft_pkg::WORK_BITS-1:0] bin_imag,
	output logic                                   ready_res
);

	r2fft_pkg::ctrl_t ctl;
	logic [$clog2(POINTS)-1:0] addr;
	logic [$clog2(POINTS)-2:0] tw_idx;

	r2fft_ctrl #(.POINTS(POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.bin_index(bin_index), .busy(busy), .done(done), .ctl(ctl),
		.addr(addr), .tw_idx(tw_idx));

	r2fft_datapath #(.POINTS(POINTS), .SAMPLE_BITS(SAMPLE_BITS),
		.TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .addr(addr), .tw_idx(tw_idx),
		.sample(sample), .bin_real(bin_real), .bin_imag(bin_imag),
		.ready_res(ready_res));

endmodule

// ===== bench/radix2_fft_frame_checker.sv =====
// Checker for the frame FFT: watches the command and result channels, predicts bins, compares.
module radix2_fft_frame_checker (
	input  logic                                   clk,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic                                   command,
	input  logic signed [15:0]                     sample,
	input  logic [11:0]                            bin_index,
	input  logic                                   done,
	input  logic signed [r2fft_pkg::WORK_BITS-1:0] bin_real,
	input  logic signed [r2fft_pkg::WORK_BITS-1:0] bin_imag,
	input  logic                                   ready_res,
	output int                                     fail_count,
	output int                                     bins_pending,
	output int                                     bins_checked,
	output int                                     frames_done
);

	localparam int N = 4096;
	localparam int LOG_N = 12;
	localparam int TW_SHIFT = 15;
	localparam longint WORK_MAX = (64'sd1 <<< (r2fft_pkg::WORK_BITS - 1)) - 1;

	typedef struct {
		longint re;
		longint im;
		logic   rdy;
	} bin_word_t;

	longint    fft_re[N];
	longint    fft_im[N];
	longint    cos_q15[N/2];
	longint    nsin_q15[N/2];
	int        frame_fill;
	int        bins_queued;
	logic      spectrum_ready;
	bin_word_t bin_queue[$];

	// (a*b) >> 61, kept to 64 bits
	function automatic logic [63:0] q61_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[124:61];
	endfunction

	// Q61 to Q15, halves away from zero
	function automatic longint q61_to_q15(input longint v);
		logic [63:0] half;
		half = 64'd1 << 45;
		if (v >= 0)
			return longint'((64'(v) + half) >> 46);
		return -longint'((64'(-v) + half) >> 46);
	endfunction

	// Taylor series for cos and sin over the first quadrant
	task automatic taylor_cos_sin(input logic [63:0] x, output longint c, output longint s);
		longint      cs;
		longint      sn;
		logic [63:0] term;
		logic        neg;
		cs = longint'(64'd1 << 61);
		sn = longint'(x);
		term = x;
		for (int n = 2; n <= 30; n++) begin
			neg = (n % 4 == 2) || (n % 4 == 3);
			term = q61_product(term, x) / 64'(n);
			if (n % 2 == 1)
				sn += neg ? -longint'(term) : longint'(term);
			else
				cs += neg ? -longint'(term) : longint'(term);
		end
		c = q61_to_q15(cs);
		s = q61_to_q15(sn);
	endtask

	function automatic longint clamp_work(input longint v);
		if (v > WORK_MAX)
			return WORK_MAX;
		if (v < -WORK_MAX - 1)
			return -WORK_MAX - 1;
		return v;
	endfunction

	// In-place decimation-in-time transform over the frame store
	task automatic transform_frame();
		int     j;
		int     half;
		int     stride;
		int     a;
		int     b;
		longint t;
		longint wr;
		longint wi;
		longint zr;
		longint zi;
		longint ar;
		longint ai;
		for (int i = 0; i < N; i++) begin
			j = 0;
			for (int k = 0; k < LOG_N; k++)
				j |= ((i >> k) & 1) << (LOG_N - 1 - k);
			if (i < j) begin
				t = fft_re[i]; fft_re[i] = fft_re[j]; fft_re[j] = t;
				t = fft_im[i]; fft_im[i] = fft_im[j]; fft_im[j] = t;
			end
		end
		for (int len = 2; len <= N; len *= 2) begin
			half = len / 2;
			stride = N / len;
			for (int base = 0; base < N; base += len) begin
				for (int m = 0; m < half; m++) begin
					a = base + m;
					b = a + half;
					wr = cos_q15[(m * stride) % (N/2)];
					wi = nsin_q15[(m * stride) % (N/2)];
					zr = (wr * fft_re[b] - wi * fft_im[b] + (64'sd1 <<< (TW_SHIFT - 1))) >>> TW_SHIFT;
					zi = (wr * fft_im[b] + wi * fft_re[b] + (64'sd1 <<< (TW_SHIFT - 1))) >>> TW_SHIFT;
					ar = fft_re[a];
					ai = fft_im[a];
					fft_re[a] = clamp_work(ar + zr);
					fft_im[a] = clamp_work(ai + zi);
					fft_re[b] = clamp_work(ar - zr);
					fft_im[b] = clamp_work(ai - zi);
				end
			end
		end
	endtask

	// Twiddle table and initial state
	initial begin
		logic [63:0] step;
		longint      c;
		longint      s;
		step = 64'h6487ED5110B4611A / 64'(N/2);
		for (int k = 0; k < N/2; k++) begin
			if (k <= N/4) begin
				taylor_cos_sin(step * 64'(k), c, s);
			end else begin
				taylor_cos_sin(step * 64'(N/2 - k), c, s);
				c = -c;
			end
			cos_q15[k] = (c > 32767) ? 32767 : c;
			nsin_q15[k] = -s;
		end
		frame_fill = 0;
		spectrum_ready = 1'b0;
		fail_count = 0;
		bins_checked = 0;
		bins_queued = 0;
		frames_done = 0;
	end

	assign bins_pending = bins_queued - bins_checked;

	// Accepted commands: write into the frame or predict a bin word
	always @(posedge clk) begin
		bin_word_t w;
		if (start && !busy) begin
			if (command == 1'(r2fft_pkg::CMD_WRITE)) begin
				if (frame_fill == 0)
					spectrum_ready = 1'b0;
				fft_re[frame_fill] = longint'(sample);
				fft_im[frame_fill] = 0;
				frame_fill++;
				if (frame_fill == N) begin
					transform_frame();
					spectrum_ready = 1'b1;
					frame_fill = 0;
					frames_done++;
				end
			end else begin
				w.rdy = spectrum_ready;
				w.re = spectrum_ready ? fft_re[bin_index] : 0;
				w.im = spectrum_ready ? fft_im[bin_index] : 0;
				bin_queue.push_back(w);
				bins_queued++;
			end
		end
	end

	// Result words against the oldest prediction
	always @(posedge clk) begin
		bin_word_t w;
		if (done) begin
			if (bin_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected bin word: re=%0d im=%0d rdy=%0b",
						bin_real, bin_imag, ready_res);
			end else begin
				w = bin_queue.pop_front();
				bins_checked++;
				if (longint'(bin_real) != w.re || longint'(bin_imag) != w.im
						|| ready_res != w.rdy) begin
					fail_count++;
					if (fail_count <= 10)
						$display("bin word wrong: want re=%0d im=%0d rdy=%0b, got re=%0d im=%0d rdy=%0b",
							w.re, w.im, w.rdy, bin_real, bin_imag, ready_res);
				end
			end
		end
	end

endmodule

// ===== bench/radix2_fft_frame_top_test.sv =====
// Stimulus and verdict for the frame FFT: sample frames, bin reads, random gaps.
module radix2_fft_frame_top_test;

	localparam int N = 4096;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   start = 1'b0;
	logic                                   command = 1'b0;
	logic signed [15:0]                     sample = '0;
	logic [11:0]                            bin_index = '0;
	logic                                   busy;
	logic                                   done;
	logic signed [r2fft_pkg::WORK_BITS-1:0] bin_real;
	logic signed [r2fft_pkg::WORK_BITS-1:0] bin_imag;
	logic                                   ready_res;
	int                                     fail_count;
	int                                     bins_pending;
	int                                     bins_checked;
	int                                     frames_done;
	logic                                   steady;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	radix2_fft_frame_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.command(command), .sample(sample), .bin_index(bin_index),
		.bin_real(bin_real), .bin_imag(bin_imag), .ready_res(ready_res)
	);

	radix2_fft_frame_checker chk (
		.clk(clk), .start(start), .busy(busy), .command(command), .sample(sample),
		.bin_index(bin_index), .done(done), .bin_real(bin_real), .bin_imag(bin_imag),
		.ready_res(ready_res), .fail_count(fail_count), .bins_pending(bins_pending),
		.bins_checked(bins_checked), .frames_done(frames_done)
	);

	// Issue one word from a falling edge; returns at the falling edge after acceptance
	task automatic issue(input logic cmd, input logic signed [15:0] smp, input logic [11:0] idx);
		if (!steady && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		sample <= smp;
		bin_index <= idx;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic read_bins(input int count);
		for (int i = 0; i < count; i++)
			issue(1'(r2fft_pkg::CMD_READ), 16'($urandom), 12'($urandom_range(0, N - 1)));
	endtask

	initial begin
		#(12 * 1000000);
		$display("radix2_fft_frame_top: mismatch");
		$finish;
	end

	initial begin
		int                 cnt;
		logic signed [15:0] smp;
		steady = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reads with no finished transform
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd0);
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd4095);
		read_bins(3);

		// One frame: full-scale head, a gap-free random stretch, then mostly
		// small samples with occasional extremes; reads part way through
		for (int i = 0; i < N; i++) begin
			steady = (i >= 1024 && i < 2048);
			cnt = $urandom_range(99);
			if (i < 64)
				smp = (i == 1) ? 16'sh7FFF : 16'sh8000;
			else if (i < 2048)
				smp = 16'($urandom);
			else
				smp = (cnt < 5) ? 16'sh8000 : (cnt < 10) ? 16'sh7FFF
					: 16'(signed'($urandom_range(0, 511)) - 256);
			issue(1'(r2fft_pkg::CMD_WRITE), smp, '0);
			if (i == 0 || i == 1500 || i == N - 2)
				read_bins(2);
		end
		steady = 1'b0;

		// Edges of the spectrum, then random bins
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd0);
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd1);
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd2048);
		issue(1'(r2fft_pkg::CMD_READ), 16'sd0, 12'd4095);
		read_bins(150);

		// Start of a new frame drops the finished spectrum
		issue(1'(r2fft_pkg::CMD_WRITE), 16'sd100, '0);
		read_bins(2);
		issue(1'(r2fft_pkg::CMD_WRITE), -16'sd100, '0);
		read_bins(2);

		start <= 1'b0;
		cnt = 0;
		while (bins_pending != 0 && cnt < 1000) begin
			@(posedge clk);
			cnt++;
		end
		repeat (20) @(posedge clk);
		$display("ran %0d frames through the transform, %0d bin words checked",
			frames_done, bins_checked);
		if (fail_count == 0 && bins_pending == 0)
			$display("radix2_fft_frame_top: match");
		else
			$display("radix2_fft_frame_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/r2fft_pkg.sv
sv/r2fft_ram.sv
sv/r2fft_twiddle.sv
sv/r2fft_datapath.sv
sv/r2fft_ctrl.sv
sv/radix2_fft_frame_top.sv
bench/radix2_fft_frame_checker.sv
bench/radix2_fft_frame_top_test.sv
